[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the signal-processor register block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define SPRB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sprb assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SPRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sprb assertion failed");

`else

`define SPRB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SPRB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/sprb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprb_pkg
// Shared types and constants of the signal-processor register block.
// ----------------------------------------------------------------------------
package sprb_pkg;

   localparam int unsigned WORD_BYTES = 8;

   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      SIZE_BYTE   = 2'd0,
      SIZE_HALF   = 2'd1,
      SIZE_WORD   = 2'd2,
      SIZE_DOUBLE = 2'd3
   } size_type;

   // Block codes taken from address bits 23..12.
   localparam logic [11:0] BLK_DMEM = 12'h000;
   localparam logic [11:0] BLK_IMEM = 12'h001;
   localparam logic [11:0] BLK_CTRL = 12'h040;
   localparam logic [11:0] BLK_PC   = 12'h080;

   // Register offsets inside the control block.
   localparam logic [4:0] REG_LOCAL_ADDR = 5'h00;
   localparam logic [4:0] REG_DRAM_ADDR  = 5'h04;
   localparam logic [4:0] REG_READ_LEN   = 5'h08;
   localparam logic [4:0] REG_WRITE_LEN  = 5'h0C;
   localparam logic [4:0] REG_STATUS     = 5'h10;
   localparam logic [4:0] REG_DMA_FULL   = 5'h14;
   localparam logic [4:0] REG_DMA_BUSY   = 5'h18;
   localparam logic [4:0] REG_SEMAPHORE  = 5'h1C;

   // Register offsets inside the PC block.
   localparam logic [3:0] REG_PC   = 4'h0;
   localparam logic [3:0] REG_BIST = 4'h4;

   localparam logic [14:0] STATUS_RESET = 15'h0001;

   typedef struct packed {
      cmd_type     cmd;
      size_type    access_size;
      logic [31:0] address;
      logic [63:0] write_data;
   } sprb_access_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        bus_error;
      logic        interrupt_raise;
      logic        interrupt_clear;
      logic        task_start;
      logic        yield_taken;
      logic        dma_start;
      logic        dma_to_dram;
      logic [12:0] dma_local_address;
      logic [25:0] dma_dram_address;
      logic [12:0] dma_byte_count;
   } sprb_reg_result_type;

   typedef struct packed {
      logic       read_en;
      logic       write_en;
      logic [7:0] byte_en;
   } sprb_mem_ctl_type;

endpackage

[rtl/core/sprb_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprb_req_if
// Bus access request channel: one beat is one read or write access.
// ----------------------------------------------------------------------------
interface sprb_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [1:0]  access_size;
   logic [31:0] address;
   logic [63:0] write_data;

   modport source (output valid, output cmd, output access_size, output address,
                   output write_data, input ready);
   modport sink   (input valid, input cmd, input access_size, input address,
                   input write_data, output ready);
endinterface

[rtl/core/sprb_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprb_rsp_if
// Response channel: read data, error flag and side-effect pulses.
// ----------------------------------------------------------------------------
interface sprb_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] read_data;
   logic        bus_error;
   logic        interrupt_raise;
   logic        interrupt_clear;
   logic        task_start;
   logic        yield_taken;
   logic        dma_start;
   logic        dma_to_dram;
   logic [12:0] dma_local_address;
   logic [25:0] dma_dram_address;
   logic [12:0] dma_byte_count;

   modport source (output valid, output read_data, output bus_error,
                   output interrupt_raise, output interrupt_clear, output task_start,
                   output yield_taken, output dma_start, output dma_to_dram,
                   output dma_local_address, output dma_dram_address,
                   output dma_byte_count, input ready);
   modport sink   (input valid, input read_data, input bus_error,
                   input interrupt_raise, input interrupt_clear, input task_start,
                   input yield_taken, input dma_start, input dma_to_dram,
                   input dma_local_address, input dma_dram_address,
                   input dma_byte_count, output ready);
endinterface

[rtl/core/sprb_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprb_mem
// Single-port 64-bit local memory with byte enables and a registered read.
// ----------------------------------------------------------------------------
module sprb_mem #(
   parameter int unsigned DEPTH = 512
) (
   input  logic                       clock,
   input  sprb_pkg::sprb_mem_ctl_type ctl,
   input  logic [$clog2(DEPTH)-1:0]   index,
   input  logic [63:0]                write_data,
   output logic [63:0]                read_data
);
   import sprb_pkg::*;

   logic [63:0] mem_array [DEPTH];
   logic [63:0] read_data_ff;

   // Byte lane 7 holds the lowest byte address of the word (big-endian).
   always_ff @(posedge clock) begin
      if (ctl.write_en) begin
         for (int b = 0; b < WORD_BYTES; b++) begin
            if (ctl.byte_en[b]) begin
               mem_array[index][b*8 +: 8] <= write_data[b*8 +: 8];
            end
         end
      end
      if (ctl.read_en) begin
         read_data_ff <= mem_array[index];
      end
   end

   assign read_data = read_data_ff;

endmodule

[rtl/core/sprb_regs.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sprb_regs
// Control registers: DMA address and length, status, semaphore, PC and BIST.
// ----------------------------------------------------------------------------
module sprb_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  sprb_pkg::sprb_access_type     access,
   input  logic                          fire,
   output sprb_pkg::sprb_reg_result_type result
);
   import sprb_pkg::*;

   logic [14:0] status_ff, status_in;
   logic [12:0] local_addr_ff, local_addr_in;
   logic [25:0] dram_addr_ff, dram_addr_in;
   logic [31:0] read_len_ff, read_len_in;
   logic [31:0] write_len_ff, write_len_in;
   logic        semaphore_ff, semaphore_in;
   logic [31:0] pc_ff, pc_in;
   logic [7:0]  bist_ff, bist_in;

   logic [11:0] blk;
   logic        is_write;
   logic [31:0] w32;
   logic        sem_read_hit;
   logic [14:0] s;

   always_comb begin
      blk          = access.address[23:12];
      is_write     = (access.cmd == CMD_WRITE);
      w32          = access.write_data[31:0];
      status_in    = status_ff;
      local_addr_in = local_addr_ff;
      dram_addr_in = dram_addr_ff;
      read_len_in  = read_len_ff;
      write_len_in = write_len_ff;
      semaphore_in = semaphore_ff;
      pc_in        = pc_ff;
      bist_in      = bist_ff;
      sem_read_hit = 1'b0;
      s            = status_ff;
      result       = '0;

      if (blk inside {BLK_DMEM, BLK_IMEM}) begin
         // Local memory accesses are handled by the memory path.
      end else if (blk == BLK_CTRL && access.access_size == SIZE_WORD) begin
         case (access.address[4:0])
            REG_LOCAL_ADDR: begin
               if (is_write) local_addr_in = w32[12:0];
               else result.read_data = {19'd0, local_addr_ff};
            end
            REG_DRAM_ADDR: begin
               if (is_write) dram_addr_in = w32[25:0];
               else result.read_data = {6'd0, dram_addr_ff};
            end
            REG_READ_LEN, REG_WRITE_LEN: begin
               if (is_write) begin
                  if (access.address[2]) write_len_in = w32;
                  else read_len_in = w32;
                  result.dma_start         = 1'b1;
                  result.dma_to_dram       = access.address[2];
                  result.dma_local_address = local_addr_ff;
                  result.dma_dram_address  = dram_addr_ff;
                  result.dma_byte_count    = {1'b0, w32[11:0]} + 13'd1;
               end else begin
                  result.read_data = access.address[2] ? write_len_ff : read_len_ff;
               end
            end
            REG_STATUS: begin
               if (is_write) begin
                  // Set/clear pairs take effect in bit order, so later bits win.
                  if (w32[0]) begin
                     s[0] = 1'b0;
                     result.task_start = 1'b1;
                  end
                  if (w32[1]) s[0] = 1'b1;
                  if (w32[2]) s[1] = 1'b0;
                  if (w32[3]) result.interrupt_clear = 1'b1;
                  if (w32[4]) result.interrupt_raise = 1'b1;
                  if (w32[5]) s[5] = 1'b0;
                  if (w32[6]) s[5] = 1'b1;
                  if (w32[7]) s[6] = 1'b0;
                  if (w32[8]) s[6] = 1'b1;
                  if (w32[9]) s[8:7] = 2'b00;
                  if (w32[10] && !s[0]) begin
                     s[0] = 1'b1;
                     s[8] = 1'b1;
                     result.yield_taken     = 1'b1;
                     result.interrupt_raise = 1'b1;
                  end
                  if (w32[11]) s[8] = 1'b0;
                  if (w32[12]) s[8] = 1'b1;
                  if (w32[13]) s[9] = 1'b0;
                  if (w32[14]) s[9] = 1'b1;
                  for (int k = 0; k < 5; k++) begin
                     if (w32[15 + 2*k]) s[10 + k] = 1'b0;
                     if (w32[16 + 2*k]) s[10 + k] = 1'b1;
                  end
                  status_in = s;
               end else begin
                  result.read_data = {17'd0, status_ff};
               end
            end
            REG_DMA_FULL, REG_DMA_BUSY: begin
               // No transfer is ever pending: reads give zero, writes are dropped.
            end
            REG_SEMAPHORE: begin
               if (is_write) begin
                  semaphore_in = 1'b0;
               end else begin
                  result.read_data = {31'd0, semaphore_ff};
                  semaphore_in     = 1'b1;
                  sem_read_hit     = 1'b1;
               end
            end
            default: result.bus_error = 1'b1;
         endcase
      end else if (blk == BLK_PC && access.access_size == SIZE_WORD) begin
         case (access.address[3:0])
            REG_PC: begin
               if (is_write) pc_in = w32;
               else result.read_data = pc_ff;
            end
            REG_BIST: begin
               if (is_write) bist_in = w32[7:0];
               else result.read_data = {24'd0, bist_ff};
            end
            default: result.bus_error = 1'b1;
         endcase
      end else begin
         result.bus_error = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff     <= STATUS_RESET;
         local_addr_ff <= '0;
         dram_addr_ff  <= '0;
         read_len_ff   <= '0;
         write_len_ff  <= '0;
         semaphore_ff  <= 1'b0;
         pc_ff         <= '0;
         bist_ff       <= '0;
      end else if (fire) begin
         status_ff     <= status_in;
         local_addr_ff <= local_addr_in;
         dram_addr_ff  <= dram_addr_in;
         read_len_ff   <= read_len_in;
         write_len_ff  <= write_len_in;
         semaphore_ff  <= semaphore_in;
         pc_ff         <= pc_in;
         bist_ff       <= bist_in;
      end
   end

   `SPRB_ASSERT_NEXT(a_sem_read_sets, clock, reset, fire && sem_read_hit, semaphore_ff)
   `SPRB_ASSERT_IMPLY(a_status_after_reset, clock, reset, $past(reset),
                      status_ff == STATUS_RESET)
   `SPRB_ASSERT_IMPLY(a_dma_only_on_write, clock, reset, result.dma_start,
                      is_write && !result.bus_error)

endmodule

[rtl/core/sp_register_block_core.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sp_register_block_core
// Signal-processor register block: local data and instruction memories plus
// DMA, status, semaphore, PC and BIST registers behind one bus port.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat carries
//   req_bus   in         cmd, access_size, address, write_data
//   rsp_bus   out        read_data, bus_error, interrupt and task pulses, DMA request
//
// Throughput is one beat per clock cycle while rsp_bus does not stall. A response
// becomes valid once its request beat has passed the input register, the access
// stage with memory port and register file, and the result register.
// Reset is synchronous and active high; it clears the stage valids and control
// registers and holds req_bus.ready low. Memory is undefined until written.
// A stage advances when the next one is empty or moving, so requests flow on
// while a finished response waits, as long as an earlier stage has a free slot.
// ----------------------------------------------------------------------------
module sp_register_block_core #(
   parameter int unsigned MEM_BYTES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   sprb_req_if.sink   req_bus,
   sprb_rsp_if.source rsp_bus
);
   import sprb_pkg::*;

   // MEM_BYTES is a power of two; offsets beyond it wrap.
   localparam int unsigned MEM_DEPTH = MEM_BYTES / WORD_BYTES;
   localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

   // What the access stage hands on to the result stage.
   typedef struct packed {
      logic                mem_read;
      logic                imem_sel;
      size_type            access_size;
      logic [2:0]          lane;
      sprb_reg_result_type regs;
   } stage_b_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        bus_error;
      logic        interrupt_raise;
      logic        interrupt_clear;
      logic        task_start;
      logic        yield_taken;
      logic        dma_start;
      logic        dma_to_dram;
      logic [12:0] dma_local_address;
      logic [25:0] dma_dram_address;
      logic [12:0] dma_byte_count;
   } rsp_type;

   // Highest byte index within the access, i.e. access width minus one.
   function automatic logic [2:0] size_last(size_type sz);
      logic [2:0] m;
      case (sz)
         SIZE_BYTE:   m = 3'd0;
         SIZE_HALF:   m = 3'd1;
         SIZE_WORD:   m = 3'd3;
         SIZE_DOUBLE: m = 3'd7;
         default:     m = 3'd0;
      endcase
      return m;
   endfunction

   function automatic logic [7:0] size_bytes(size_type sz);
      logic [7:0] m;
      case (sz)
         SIZE_BYTE:   m = 8'h01;
         SIZE_HALF:   m = 8'h03;
         SIZE_WORD:   m = 8'h0F;
         SIZE_DOUBLE: m = 8'hFF;
         default:     m = 8'h00;
      endcase
      return m;
   endfunction

   // ---------------------------------------------------------------- handshake
   logic valid_a_ff, valid_a_in;
   logic valid_b_ff, valid_b_in;
   logic valid_c_ff, valid_c_in;
   logic ready_a, ready_b, ready_c;
   logic accept, a_to_b, b_to_c;

   assign ready_c = !valid_c_ff || rsp_bus.ready;
   assign ready_b = !valid_b_ff || ready_c;
   assign ready_a = (!valid_a_ff || ready_b) && !reset;
   assign accept  = req_bus.valid && ready_a;
   assign a_to_b  = valid_a_ff && ready_b;
   assign b_to_c  = valid_b_ff && ready_c;

   assign req_bus.ready = ready_a;

   always_comb begin
      valid_a_in = accept ? 1'b1 : (a_to_b ? 1'b0 : valid_a_ff);
      valid_b_in = a_to_b ? 1'b1 : (b_to_c ? 1'b0 : valid_b_ff);
      valid_c_in = b_to_c ? 1'b1 : ((valid_c_ff && rsp_bus.ready) ? 1'b0 : valid_c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         valid_c_ff <= valid_c_in;
      end
   end

   // ------------------------------------------------------------ input stage
   sprb_access_type access_a_ff, access_a_in;

   always_comb begin
      access_a_in.cmd         = cmd_type'(req_bus.cmd);
      access_a_in.access_size = size_type'(req_bus.access_size);
      access_a_in.address     = req_bus.address;
      access_a_in.write_data  = req_bus.write_data;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         access_a_ff <= access_a_in;
      end
   end

   // ----------------------------------------------------------- access stage
   // The offset is aligned down to the access width, so every access stays in
   // one 64-bit word. lane is the byte lane of the last byte of the access.
   logic [11:0]         blk_a;
   logic                dmem_hit, imem_hit, write_a;
   logic [2:0]          last_a, lane_a;
   logic [MEM_AW-1:0]   mem_index;
   logic [63:0]         mem_wdata;
   logic [7:0]          mem_bytes;
   sprb_mem_ctl_type    dmem_ctl, imem_ctl;
   logic [63:0]         dmem_rdata, imem_rdata;
   sprb_reg_result_type regs_result;

   always_comb begin
      blk_a     = access_a_ff.address[23:12];
      dmem_hit  = (blk_a == BLK_DMEM);
      imem_hit  = (blk_a == BLK_IMEM);
      write_a   = (access_a_ff.cmd == CMD_WRITE);
      last_a    = size_last(access_a_ff.access_size);
      lane_a    = ~(access_a_ff.address[2:0] | last_a);
      mem_index = MEM_AW'(access_a_ff.address[11:3]);
      mem_wdata = access_a_ff.write_data << {lane_a, 3'b000};
      mem_bytes = size_bytes(access_a_ff.access_size) << lane_a;

      dmem_ctl.read_en  = a_to_b && dmem_hit && !write_a;
      dmem_ctl.write_en = a_to_b && dmem_hit && write_a;
      dmem_ctl.byte_en  = mem_bytes;
      imem_ctl.read_en  = a_to_b && imem_hit && !write_a;
      imem_ctl.write_en = a_to_b && imem_hit && write_a;
      imem_ctl.byte_en  = mem_bytes;
   end

   sprb_mem #(
      .DEPTH (MEM_DEPTH)
   ) u_dmem (
      .clock      (clock),
      .ctl        (dmem_ctl),
      .index      (mem_index),
      .write_data (mem_wdata),
      .read_data  (dmem_rdata)
   );

   sprb_mem #(
      .DEPTH (MEM_DEPTH)
   ) u_imem (
      .clock      (clock),
      .ctl        (imem_ctl),
      .index      (mem_index),
      .write_data (mem_wdata),
      .read_data  (imem_rdata)
   );

   // Register side effects commit at the same edge the memory is accessed.
   sprb_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .access (access_a_ff),
      .fire   (a_to_b),
      .result (regs_result)
   );

   stage_b_type stage_b_ff, stage_b_in;

   always_comb begin
      stage_b_in.mem_read    = (dmem_hit || imem_hit) && !write_a;
      stage_b_in.imem_sel    = imem_hit;
      stage_b_in.access_size = access_a_ff.access_size;
      stage_b_in.lane        = lane_a;
      stage_b_in.regs        = regs_result;
   end

   always_ff @(posedge clock) begin
      if (a_to_b) begin
         stage_b_ff <= stage_b_in;
      end
   end

   // ----------------------------------------------------------- result stage
   // Memory reads are shifted down to the right and masked to their width;
   // register reads already come zeroed for writes and errors.
   rsp_type     rsp_c_ff, rsp_c_in;
   logic [63:0] word_b, shifted_b, mask_b;

   always_comb begin
      word_b    = stage_b_ff.imem_sel ? imem_rdata : dmem_rdata;
      shifted_b = word_b >> {stage_b_ff.lane, 3'b000};
      case (stage_b_ff.access_size)
         SIZE_BYTE:   mask_b = 64'h0000_0000_0000_00FF;
         SIZE_HALF:   mask_b = 64'h0000_0000_0000_FFFF;
         SIZE_WORD:   mask_b = 64'h0000_0000_FFFF_FFFF;
         SIZE_DOUBLE: mask_b = 64'hFFFF_FFFF_FFFF_FFFF;
         default:     mask_b = 64'h0;
      endcase

      rsp_c_in.read_data = stage_b_ff.mem_read ? (shifted_b & mask_b)
                                               : {32'd0, stage_b_ff.regs.read_data};
      rsp_c_in.bus_error         = stage_b_ff.regs.bus_error;
      rsp_c_in.interrupt_raise   = stage_b_ff.regs.interrupt_raise;
      rsp_c_in.interrupt_clear   = stage_b_ff.regs.interrupt_clear;
      rsp_c_in.task_start        = stage_b_ff.regs.task_start;
      rsp_c_in.yield_taken       = stage_b_ff.regs.yield_taken;
      rsp_c_in.dma_start         = stage_b_ff.regs.dma_start;
      rsp_c_in.dma_to_dram       = stage_b_ff.regs.dma_to_dram;
      rsp_c_in.dma_local_address = stage_b_ff.regs.dma_local_address;
      rsp_c_in.dma_dram_address  = stage_b_ff.regs.dma_dram_address;
      rsp_c_in.dma_byte_count    = stage_b_ff.regs.dma_byte_count;
   end

   always_ff @(posedge clock) begin
      if (b_to_c) begin
         rsp_c_ff <= rsp_c_in;
      end
   end

   assign rsp_bus.valid             = valid_c_ff;
   assign rsp_bus.read_data         = rsp_c_ff.read_data;
   assign rsp_bus.bus_error         = rsp_c_ff.bus_error;
   assign rsp_bus.interrupt_raise   = rsp_c_ff.interrupt_raise;
   assign rsp_bus.interrupt_clear   = rsp_c_ff.interrupt_clear;
   assign rsp_bus.task_start        = rsp_c_ff.task_start;
   assign rsp_bus.yield_taken       = rsp_c_ff.yield_taken;
   assign rsp_bus.dma_start         = rsp_c_ff.dma_start;
   assign rsp_bus.dma_to_dram       = rsp_c_ff.dma_to_dram;
   assign rsp_bus.dma_local_address = rsp_c_ff.dma_local_address;
   assign rsp_bus.dma_dram_address  = rsp_c_ff.dma_dram_address;
   assign rsp_bus.dma_byte_count    = rsp_c_ff.dma_byte_count;

   `SPRB_ASSERT_IMPLY(a_yield_raises_irq, clock, reset,
                      valid_b_ff && stage_b_ff.regs.yield_taken,
                      stage_b_ff.regs.interrupt_raise)
   `SPRB_ASSERT_IMPLY(a_mem_read_no_error, clock, reset,
                      valid_b_ff && stage_b_ff.mem_read, !stage_b_ff.regs.bus_error)
   `SPRB_ASSERT_NEXT(a_error_zero_data, clock, reset,
                     b_to_c && stage_b_ff.regs.bus_error, rsp_c_ff.read_data == 64'd0)

endmodule

[tb/sp_register_block_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sp_register_block_core_test
// Self-checking bench for the signal-processor register block. A queue of bus
// accesses, directed first and then random, feeds a clocked driver. A clocked
// monitor compares every response beat, field by field, with the outcome that
// an in-bench shadow of the memories and registers predicts. Both sides idle
// at random.
// ----------------------------------------------------------------------------
module sp_register_block_core_test;
   import sprb_pkg::*;

   localparam int unsigned MEM_BYTES     = 4096;
   localparam int unsigned BEAT_TARGET   = 1400;
   localparam int unsigned MAX_PAUSE     = 10;
   localparam int unsigned DRAIN_SPACING = 300;
   localparam int unsigned IDLE_LIMIT    = 1000;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned PRINT_LIMIT   = 100;

   // Everything that one response beat carries.
   typedef struct packed {
      logic [63:0] read_data;
      logic        bus_error;
      logic        interrupt_raise;
      logic        interrupt_clear;
      logic        task_start;
      logic        yield_taken;
      logic        dma_start;
      logic        dma_to_dram;
      logic [12:0] dma_local_address;
      logic [25:0] dma_dram_address;
      logic [12:0] dma_byte_count;
   } access_outcome_type;

   // A queued access. When hold_for_drain is set, the driver keeps it back
   // until every earlier response has come home.
   typedef struct packed {
      sprb_access_type access;
      bit              hold_for_drain;
   } queued_access_type;

   logic clock;
   logic reset;

   sprb_req_if req_bus ();
   sprb_rsp_if rsp_bus ();

   sp_register_block_core #(
      .MEM_BYTES(MEM_BYTES)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Stimulus side.
   queued_access_type pending_accesses[$];
   bit              byte_written[2][MEM_BYTES];
   bit              drain_due;
   int unsigned     accesses_queued;
   int unsigned     accesses_accepted;
   sprb_access_type access_on_bus;
   int unsigned     send_gap;
   bit              send_calm;

   // Shadow of the block state, advanced once per accepted access.
   logic [7:0]      shadow_mem[2][MEM_BYTES];
   logic [14:0]     status_q;
   logic [12:0]     local_addr_q;
   logic [25:0]     dram_addr_q;
   logic [31:0]     read_len_q;
   logic [31:0]     write_len_q;
   logic            semaphore_q;
   logic [31:0]     pc_q;
   logic [7:0]      bist_q;

   // Response side.
   access_outcome_type awaited_outcomes[$];
   int unsigned     results_seen;
   int unsigned     mismatch_count;
   int unsigned     recv_stall;
   bit              recv_calm;
   int unsigned     idle_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Helpers for building accesses. Address bits that the block ignores are
   // filled at random so that every address bit toggles.
   // ------------------------------------------------------------------------
   function automatic sprb_access_type beat(cmd_type c, size_type s, logic [31:0] addr,
                                            logic [63:0] data);
      sprb_access_type a;
      a.cmd         = c;
      a.access_size = s;
      a.address     = addr;
      a.write_data  = data;
      return a;
   endfunction

   function automatic logic [31:0] ctrl_addr(logic [4:0] reg_off);
      return {8'($urandom), BLK_CTRL, 7'($urandom), reg_off};
   endfunction

   function automatic logic [31:0] pc_addr(logic [3:0] reg_off);
      return {8'($urandom), BLK_PC, 8'($urandom), reg_off};
   endfunction

   function automatic logic [31:0] mem_addr(logic [11:0] blk, logic [11:0] off);
      return {8'($urandom), blk, off};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int unsigned draw_pause(bit calm);
      return calm ? 0 : $urandom_range(0, MAX_PAUSE);
   endfunction

   // Appends one access to the queue. Memory bytes have no defined value
   // until written, so a read that would touch an unwritten byte is turned
   // into a write of the same bytes.
   task automatic queue_access(sprb_access_type a);
      queued_access_type q;
      logic [11:0]    blk;
      int unsigned    m;
      int unsigned    n;
      int unsigned    base;
      bit             complete;
      blk = a.address[23:12];
      if (blk == BLK_DMEM || blk == BLK_IMEM) begin
         m        = (blk == BLK_IMEM) ? 1 : 0;
         n        = 1 << a.access_size;
         base     = a.address[11:0] & ~(n - 1);
         complete = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (!byte_written[m][base + i]) complete = 1'b0;
         end
         if (!complete) a.cmd = CMD_WRITE;
         if (a.cmd == CMD_WRITE) begin
            for (int i = 0; i < n; i++) byte_written[m][base + i] = 1'b1;
         end
      end
      q.access         = a;
      q.hold_for_drain = drain_due;
      drain_due        = 1'b0;
      pending_accesses.push_back(q);
      accesses_queued++;
   endtask

   function automatic logic [4:0] any_ctrl_reg();
      case ($urandom_range(0, 8))
         0:       return REG_LOCAL_ADDR;
         1:       return REG_DRAM_ADDR;
         2:       return REG_READ_LEN;
         3:       return REG_WRITE_LEN;
         4:       return REG_STATUS;
         5:       return REG_DMA_FULL;
         6:       return REG_DMA_BUSY;
         7:       return REG_SEMAPHORE;
         default: return 5'($urandom);
      endcase
   endfunction

   // Status write data: either a single command bit or a random mix of them.
   function automatic logic [63:0] status_command();
      if ($urandom_range(0, 1) != 0) return rand64();
      return 64'(1) << $urandom_range(0, 24);
   endfunction

   // One random step of traffic: a memory access, a DMA setup or task
   // start/yield sequence, a lone register access, or a stray address.
   task automatic queue_random_traffic();
      int unsigned pick;
      logic [11:0] blk;
      logic [11:0] off;
      size_type    sz;
      pick = $urandom_range(0, 99);
      sz   = ($urandom_range(0, 9) == 0) ? size_type'($urandom_range(0, 3)) : SIZE_WORD;
      if (pick < 40) begin
         // Mostly a small window so that reads find written bytes.
         blk = ($urandom_range(0, 1) != 0) ? BLK_IMEM : BLK_DMEM;
         off = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 255)) : 12'($urandom);
         queue_access(beat(cmd_type'($urandom_range(0, 1)), size_type'($urandom_range(0, 3)),
                           mem_addr(blk, off), rand64()));
      end else if (pick < 50) begin
         queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_LOCAL_ADDR), rand64()));
         queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_DRAM_ADDR), rand64()));
         queue_access(beat(CMD_WRITE, SIZE_WORD,
                           ctrl_addr(($urandom_range(0, 1) != 0) ? REG_READ_LEN : REG_WRITE_LEN),
                           rand64()));
         if ($urandom_range(0, 1) != 0)
            queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(any_ctrl_reg()), rand64()));
      end else if (pick < 58) begin
         // Start a task, then maybe ask it to yield, then look at the status.
         queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_STATUS),
                           {$urandom, 32'h0000_0001}));
         if ($urandom_range(0, 2) != 0)
            queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_STATUS),
                              {$urandom, 32'h0000_0400}));
         queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(REG_STATUS), rand64()));
      end else if (pick < 78) begin
         queue_access(beat(cmd_type'($urandom_range(0, 1)), sz,
                           ctrl_addr(any_ctrl_reg()), status_command()));
      end else if (pick < 90) begin
         queue_access(beat(cmd_type'($urandom_range(0, 1)), sz,
                           pc_addr(($urandom_range(0, 5) == 0) ? 4'($urandom) :
                                   (($urandom_range(0, 1) != 0) ? REG_PC : REG_BIST)),
                           rand64()));
      end else begin
         queue_access(beat(cmd_type'($urandom_range(0, 1)), size_type'($urandom_range(0, 3)),
                           $urandom, rand64()));
      end
   endtask

   // ------------------------------------------------------------------------
   // Prediction: applies one accepted access to the shadow state and returns
   // the response it must produce.
   // ------------------------------------------------------------------------
   function automatic access_outcome_type predict_access_outcome(sprb_access_type a);
      access_outcome_type o;
      logic [11:0]     blk;
      logic [31:0]     w;
      logic [24:0]     d;
      logic [14:0]     s;
      int unsigned     m;
      int unsigned     n;
      int unsigned     base;
      bit              wr;
      o   = '0;
      blk = a.address[23:12];
      w   = a.write_data[31:0];
      wr  = (a.cmd == CMD_WRITE);
      if (blk == BLK_DMEM || blk == BLK_IMEM) begin
         // Memories are big-endian; the offset is aligned down to the width.
         m    = (blk == BLK_IMEM) ? 1 : 0;
         n    = 1 << a.access_size;
         base = a.address[11:0] & ~(n - 1);
         for (int i = 0; i < n; i++) begin
            if (wr) shadow_mem[m][(base + i) % MEM_BYTES] = a.write_data[8 * (n - 1 - i) +: 8];
            else o.read_data = {o.read_data[55:0], shadow_mem[m][(base + i) % MEM_BYTES]};
         end
      end else if (blk == BLK_CTRL && a.access_size == SIZE_WORD) begin
         case (a.address[4:0])
            REG_LOCAL_ADDR: begin
               if (wr) local_addr_q = w[12:0];
               else o.read_data = 64'(local_addr_q);
            end
            REG_DRAM_ADDR: begin
               if (wr) dram_addr_q = w[25:0];
               else o.read_data = 64'(dram_addr_q);
            end
            REG_READ_LEN, REG_WRITE_LEN: begin
               if (wr) begin
                  // A length write launches a transfer with the current addresses.
                  o.dma_start         = 1'b1;
                  o.dma_to_dram       = (a.address[4:0] == REG_WRITE_LEN);
                  o.dma_local_address = local_addr_q;
                  o.dma_dram_address  = dram_addr_q;
                  o.dma_byte_count    = 13'(w[11:0]) + 13'd1;
                  if (a.address[4:0] == REG_WRITE_LEN) write_len_q = w;
                  else read_len_q = w;
               end else begin
                  o.read_data = 64'((a.address[4:0] == REG_WRITE_LEN) ? write_len_q : read_len_q);
               end
            end
            REG_STATUS: begin
               if (wr) begin
                  // Command bits are applied in a fixed order, so a later bit
                  // overrides an earlier one that touches the same status bit.
                  d = w[24:0];
                  s = status_q;
                  if (d[0]) begin
                     s[0]         = 1'b0;
                     o.task_start = 1'b1;
                  end
                  if (d[1]) s[0] = 1'b1;
                  if (d[2]) s[1] = 1'b0;
                  if (d[3]) o.interrupt_clear = 1'b1;
                  if (d[4]) o.interrupt_raise = 1'b1;
                  if (d[5]) s[5] = 1'b0;
                  if (d[6]) s[5] = 1'b1;
                  if (d[7]) s[6] = 1'b0;
                  if (d[8]) s[6] = 1'b1;
                  if (d[9]) s[8:7] = 2'b00;
                  // Yield only bites on a running processor: it halts it and
                  // flags the yield, which also raises the interrupt.
                  if (d[10] && !s[0]) begin
                     s[0]              = 1'b1;
                     s[8]              = 1'b1;
                     o.yield_taken     = 1'b1;
                     o.interrupt_raise = 1'b1;
                  end
                  if (d[11]) s[8] = 1'b0;
                  if (d[12]) s[8] = 1'b1;
                  if (d[13]) s[9] = 1'b0;
                  if (d[14]) s[9] = 1'b1;
                  for (int k = 0; k < 5; k++) begin
                     if (d[15 + 2 * k]) s[10 + k] = 1'b0;
                     if (d[16 + 2 * k]) s[10 + k] = 1'b1;
                  end
                  status_q = s;
               end else begin
                  o.read_data = 64'(status_q);
               end
            end
            REG_DMA_FULL, REG_DMA_BUSY: begin
               // No transfer is ever pending: reads give zero, writes do nothing.
            end
            REG_SEMAPHORE: begin
               if (wr) begin
                  semaphore_q = 1'b0;
               end else begin
                  o.read_data = 64'(semaphore_q);
                  semaphore_q = 1'b1;
               end
            end
            default: o.bus_error = 1'b1;
         endcase
      end else if (blk == BLK_PC && a.access_size == SIZE_WORD) begin
         case (a.address[3:0])
            REG_PC: begin
               if (wr) pc_q = w;
               else o.read_data = 64'(pc_q);
            end
            REG_BIST: begin
               if (wr) bist_q = w[7:0];
               else o.read_data = 64'(bist_q);
            end
            default: o.bus_error = 1'b1;
         endcase
      end else begin
         o.bus_error = 1'b1;
      end
      if (o.bus_error || wr) o.read_data = '0;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Checking.
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("tb: mismatch in %s at result %0d: got %h, expected %h",
                  what, results_seen, got, want);
   endtask

   task automatic compare_outcome(access_outcome_type got, access_outcome_type want);
      if (got.read_data !== want.read_data)
         report_mismatch("read_data", got.read_data, want.read_data);
      if (got.bus_error !== want.bus_error)
         report_mismatch("bus_error", 64'(got.bus_error), 64'(want.bus_error));
      if (got.interrupt_raise !== want.interrupt_raise)
         report_mismatch("interrupt_raise", 64'(got.interrupt_raise), 64'(want.interrupt_raise));
      if (got.interrupt_clear !== want.interrupt_clear)
         report_mismatch("interrupt_clear", 64'(got.interrupt_clear), 64'(want.interrupt_clear));
      if (got.task_start !== want.task_start)
         report_mismatch("task_start", 64'(got.task_start), 64'(want.task_start));
      if (got.yield_taken !== want.yield_taken)
         report_mismatch("yield_taken", 64'(got.yield_taken), 64'(want.yield_taken));
      if (got.dma_start !== want.dma_start)
         report_mismatch("dma_start", 64'(got.dma_start), 64'(want.dma_start));
      if (got.dma_to_dram !== want.dma_to_dram)
         report_mismatch("dma_to_dram", 64'(got.dma_to_dram), 64'(want.dma_to_dram));
      if (got.dma_local_address !== want.dma_local_address)
         report_mismatch("dma_local_address", 64'(got.dma_local_address),
                         64'(want.dma_local_address));
      if (got.dma_dram_address !== want.dma_dram_address)
         report_mismatch("dma_dram_address", 64'(got.dma_dram_address),
                         64'(want.dma_dram_address));
      if (got.dma_byte_count !== want.dma_byte_count)
         report_mismatch("dma_byte_count", 64'(got.dma_byte_count), 64'(want.dma_byte_count));
   endtask

   // ------------------------------------------------------------------------
   // Driver. An access stays on the bus until the beat is taken; after it, a
   // random gap may follow. An access marked for draining waits until no
   // response is outstanding.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      queued_access_type next_access;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
         status_q      = STATUS_RESET;
         local_addr_q  = '0;
         dram_addr_q   = '0;
         read_len_q    = '0;
         write_len_q   = '0;
         semaphore_q   = 1'b0;
         pc_q          = '0;
         bist_q        = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            awaited_outcomes.push_back(predict_access_outcome(access_on_bus));
            accesses_accepted++;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // Stalled: hold the beat as it is.
         end else if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap      <= send_gap - 1;
         end else if (pending_accesses.size() != 0 &&
                      !(pending_accesses[0].hold_for_drain && awaited_outcomes.size() != 0)) begin
            next_access           = pending_accesses.pop_front();
            access_on_bus         = next_access.access;
            req_bus.valid       <= 1'b1;
            req_bus.cmd         <= next_access.access.cmd;
            req_bus.access_size <= next_access.access.access_size;
            req_bus.address     <= next_access.access.address;
            req_bus.write_data  <= next_access.access.write_data;
            if ($urandom_range(0, send_calm ? 19 : 39) == 0) send_calm = !send_calm;
            send_gap <= draw_pause(send_calm);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. Checks each response beat against the oldest prediction, then
   // may hold ready low for a random pause.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      access_outcome_type got;
      int unsigned     stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall    <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.read_data         = rsp_bus.read_data;
            got.bus_error         = rsp_bus.bus_error;
            got.interrupt_raise   = rsp_bus.interrupt_raise;
            got.interrupt_clear   = rsp_bus.interrupt_clear;
            got.task_start        = rsp_bus.task_start;
            got.yield_taken       = rsp_bus.yield_taken;
            got.dma_start         = rsp_bus.dma_start;
            got.dma_to_dram       = rsp_bus.dma_to_dram;
            got.dma_local_address = rsp_bus.dma_local_address;
            got.dma_dram_address  = rsp_bus.dma_dram_address;
            got.dma_byte_count    = rsp_bus.dma_byte_count;
            if (awaited_outcomes.size() == 0)
               report_mismatch("unexpected response beat", got.read_data, '0);
            else
               compare_outcome(got, awaited_outcomes.pop_front());
            results_seen++;
            if ($urandom_range(0, recv_calm ? 19 : 39) == 0) recv_calm = !recv_calm;
            stall = draw_pause(recv_calm);
            rsp_bus.ready <= (stall == 0);
            recv_stall    <= stall;
         end else if (recv_stall != 0) begin
            rsp_bus.ready <= (recv_stall == 1);
            recv_stall    <= recv_stall - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Ends the run when neither channel has moved a beat for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.cmd         = 1'b0;
      req_bus.access_size = 2'b00;
      req_bus.address     = '0;
      req_bus.write_data  = '0;
      rsp_bus.ready       = 1'b0;
      drain_due           = 1'b0;
      accesses_queued     = 0;
      accesses_accepted   = 0;
      results_seen        = 0;
      mismatch_count      = 0;
      send_calm           = 1'b0;
      recv_calm           = 1'b0;
      idle_cycles         = 0;

      // Reset state, then the semaphore: the first read returns the old
      // value and sets it, a write clears it again.
      queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(REG_STATUS), '0));
      queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(REG_SEMAPHORE), '0));
      queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(REG_SEMAPHORE), '0));
      queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_SEMAPHORE), '1));
      queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(REG_SEMAPHORE), '0));
      // DMA full and busy read as zero and ignore writes.
      queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_DMA_BUSY), '1));
      queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(REG_DMA_FULL), '0));
      // DMA setup at the extremes: full-width addresses, longest and shortest.
      queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_LOCAL_ADDR), '1));
      queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_DRAM_ADDR), '1));
      queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_READ_LEN), '1));
      queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_WRITE_LEN), '0));
      queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(REG_READ_LEN), '0));
      queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(REG_DRAM_ADDR), '0));
      // Start a task, yield it, raise and clear the interrupt together, then
      // every command bit at once.
      queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_STATUS), 64'h1));
      queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_STATUS), 64'h400));
      queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_STATUS), 64'h18));
      queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(REG_STATUS), '0));
      queue_access(beat(CMD_WRITE, SIZE_WORD, ctrl_addr(REG_STATUS), '1));
      queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(REG_STATUS), '0));
      // PC and BIST at full width.
      queue_access(beat(CMD_WRITE, SIZE_WORD, pc_addr(REG_PC), '1));
      queue_access(beat(CMD_WRITE, SIZE_WORD, pc_addr(REG_BIST), '1));
      queue_access(beat(CMD_READ, SIZE_WORD, pc_addr(REG_BIST), '0));
      // Memory byte order and misaligned reads at the top and bottom.
      queue_access(beat(CMD_WRITE, SIZE_DOUBLE, mem_addr(BLK_DMEM, 12'hFF8),
                        64'h0123_4567_89AB_CDEF));
      queue_access(beat(CMD_READ, SIZE_BYTE, mem_addr(BLK_DMEM, 12'hFFF), '0));
      queue_access(beat(CMD_READ, SIZE_HALF, mem_addr(BLK_DMEM, 12'hFF9), '0));
      queue_access(beat(CMD_WRITE, SIZE_DOUBLE, mem_addr(BLK_IMEM, 12'h000),
                        64'hFEDC_BA98_7654_3210));
      queue_access(beat(CMD_READ, SIZE_WORD, mem_addr(BLK_IMEM, 12'h007), '0));
      // Decode errors: wrong width, unknown offsets, unknown block.
      queue_access(beat(CMD_READ, SIZE_HALF, ctrl_addr(REG_STATUS), '0));
      queue_access(beat(CMD_READ, SIZE_WORD, ctrl_addr(5'h01), '0));
      queue_access(beat(CMD_WRITE, SIZE_WORD, pc_addr(4'h8), '1));
      queue_access(beat(CMD_READ, SIZE_DOUBLE, {8'h00, 12'hFFF, 12'h000}, '0));

      // Random traffic. Now and then the sender waits for the block to
      // empty before it goes on.
      drain_due = 1'b1;
      while (accesses_queued < BEAT_TARGET) begin
         if (accesses_queued % DRAIN_SPACING == 0) drain_due = 1'b1;
         queue_random_traffic();
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (accesses_accepted < accesses_queued || awaited_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
